/* rtl/jns_pkg.sv */
package jns_pkg;

	// item codes
	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_EVAL = 2'd1;
	localparam logic [1:0] MODE_CLR  = 2'd2;

	// register indexes
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_THRESHOLD  = 1'b1;

	localparam logic [8:0]  NODE_COUNT_RESET = 9'd256;
	localparam logic [16:0] THRESHOLD_RESET  = 17'd6;
	localparam int unsigned QUOT_BITS = 17;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_ADD_RD, S_ADD_WR, S_DEG_U, S_DEG_V, S_DEG_CAP, S_DEG_CHK,
		S_RD_U, S_RD_V, S_POP, S_DIV_INIT, S_DIV, S_OUT, S_CLR
	} state_t;

	typedef struct packed {
		logic load;
		logic add_rd;
		logic add_wr;
		logic add_next;
		logic deg_u;
		logic deg_v;
		logic deg_cap;
		logic rd_u;
		logic rd_v;
		logic pop;
		logic div_init;
		logic div_step;
		logic out_load;
		logic clr_start;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       ep_ok;
		logic       same_ends;
		logic       side;
		logic       skip;
		logic       deg_zero;
		logic       word_last;
		logic       div_last;
		logic       clr_last;
	} status_t;

	// population count of one row word
	function automatic logic [6:0] popcount64(input logic [63:0] w);
		logic [6:0] c;
		c = '0;
		for (int i = 0; i < 64; i++) begin
			c = c + 7'(w[i]);
		end
		return c;
	endfunction

endpackage

/* rtl/jns_ctrl.sv */
module jns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  jns_pkg::status_t  st,
	output jns_pkg::cmd_t     cmd,
	output logic              busy
);
	import jns_pkg::*;

	state_t state_q, state_d;

	// state register; reset runs the store clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.mode)
					MODE_ADD:  state_d = st.ep_ok ? S_ADD_RD : S_IDLE;
					MODE_EVAL: begin
						if (st.skip) begin
							cmd.out_load = 1'b1;
							state_d      = S_IDLE;
						end else begin
							state_d = S_DEG_U;
						end
					end
					MODE_CLR: begin
						cmd.clr_start = 1'b1;
						state_d       = S_CLR;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD_RD: begin
				cmd.add_rd = 1'b1;
				state_d    = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				if (!st.side && !st.same_ends) begin
					cmd.add_next = 1'b1;
					state_d      = S_ADD_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DEG_U: begin
				cmd.deg_u = 1'b1;
				state_d   = S_DEG_V;
			end
			S_DEG_V: begin
				cmd.deg_v = 1'b1;
				state_d   = S_DEG_CAP;
			end
			S_DEG_CAP: begin
				cmd.deg_cap = 1'b1;
				state_d     = S_DEG_CHK;
			end
			S_DEG_CHK: begin
				if (st.deg_zero) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_RD_U;
				end
			end
			S_RD_U: begin
				cmd.rd_u = 1'b1;
				state_d  = S_RD_V;
			end
			S_RD_V: begin
				cmd.rd_v = 1'b1;
				state_d  = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = st.word_last ? S_DIV_INIT : S_RD_U;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/jns_datapath.sv */
module jns_datapath #(
	parameter int NODE_LIMIT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  jns_pkg::cmd_t     cmd,
	output jns_pkg::status_t  st,
	input  logic [1:0]        mode,
	input  logic [7:0]        edge_from,
	input  logic [7:0]        edge_to,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [16:0]       wr_data,
	output logic              result_valid,
	output logic [7:0]        node_u,
	output logic [7:0]        node_v,
	output logic [16:0]       score_q16,
	output logic              pair_kept,
	output logic              sweep_done
);
	import jns_pkg::*;

	localparam int RW    = (NODE_LIMIT + 63) / 64;
	localparam int DEPTH = NODE_LIMIT * RW;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(NODE_LIMIT);
	localparam int DW    = $clog2(NODE_LIMIT + 1);
	localparam int KW    = (RW > 1) ? $clog2(RW) : 1;
	localparam int CW    = (DW > 9) ? DW : 9;

	// configuration registers
	logic [8:0]  node_count_q;
	logic [16:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			threshold_q  <= THRESHOLD_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_NODE_COUNT: node_count_q <= wr_data[8:0];
				REG_THRESHOLD:  threshold_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// latched item
	logic [1:0] mode_q;
	logic [7:0] from_q, to_q;
	logic       side_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			from_q <= edge_from;
			to_q   <= edge_to;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 1'b0;
		end else if (cmd.load) begin
			side_q <= 1'b0;
		end else if (cmd.add_next) begin
			side_q <= 1'b1;
		end
	end

	// adjacency and degree stores
	logic [63:0]   adj_mem [DEPTH];
	logic [DW-1:0] deg_mem [NODE_LIMIT];
	logic [63:0]   adj_rd_q;
	logic [DW-1:0] deg_rd_q;
	logic [AW-1:0] adj_ra, adj_wa, add_addr_q;
	logic [NW-1:0] deg_ra, deg_wa, add_row_q;
	logic          adj_we, deg_we;
	logic [63:0]   adj_wd;
	logic [DW-1:0] deg_wd;
	logic [AW-1:0] clr_idx_q;

	// sweep state
	logic [CW-1:0] cur_u_q, cur_v_q;
	logic          fin_q;
	logic [KW-1:0] k_q;
	logic [DW-1:0] du_q, dv_q, inter_q, uni_q;
	logic [DW:0]   rem_q;
	logic [16:0]   quot_q;
	logic [4:0]    div_cnt_q;
	logic [63:0]   wu_q;

	// add-edge addressing
	logic [7:0]    add_row8, add_col8;
	logic [NW-1:0] add_row;
	logic [AW-1:0] add_addr;
	logic [5:0]    col_bit_q;
	logic [AW-1:0] u_addr, v_addr;

	assign add_row8 = side_q ? to_q : from_q;
	assign add_col8 = side_q ? from_q : to_q;
	assign add_row  = NW'(add_row8);
	assign add_addr = AW'(add_row) * AW'(RW) + AW'(add_col8[7:6]);
	assign u_addr   = AW'(cur_u_q) * AW'(RW) + AW'(k_q);
	assign v_addr   = AW'(cur_v_q) * AW'(RW) + AW'(k_q);

	always_ff @(posedge clk) begin
		if (cmd.add_rd) begin
			add_addr_q <= add_addr;
			add_row_q  <= add_row;
			col_bit_q  <= add_col8[5:0];
		end
	end

	// read address selection
	always_comb begin
		adj_ra = add_addr;
		deg_ra = add_row;
		if (cmd.rd_u) adj_ra = u_addr;
		if (cmd.rd_v) adj_ra = v_addr;
		if (cmd.deg_u) deg_ra = NW'(cur_u_q);
		if (cmd.deg_v) deg_ra = NW'(cur_v_q);
	end

	// write selection: clearing pass or new edge bit
	logic bit_set;
	assign bit_set = adj_rd_q[col_bit_q];

	always_comb begin
		adj_we = 1'b0;
		deg_we = 1'b0;
		adj_wa = add_addr_q;
		deg_wa = add_row_q;
		adj_wd = adj_rd_q | (64'd1 << col_bit_q);
		deg_wd = deg_rd_q + DW'(1);
		if (cmd.clr_step) begin
			adj_we = 1'b1;
			adj_wa = clr_idx_q;
			adj_wd = '0;
			deg_we = (32'(clr_idx_q) < NODE_LIMIT);
			deg_wa = NW'(clr_idx_q);
			deg_wd = '0;
		end else if (cmd.add_wr && !bit_set) begin
			adj_we = 1'b1;
			deg_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_wa] <= adj_wd;
		adj_rd_q <= adj_mem[adj_ra];
	end

	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		deg_rd_q <= deg_mem[deg_ra];
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_start) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	// active node count, clamped
	logic [CW-1:0] nc, n_eff;
	always_comb begin
		nc = CW'(node_count_q);
		if (nc < CW'(2)) n_eff = CW'(2);
		else if (32'(nc) > NODE_LIMIT) n_eff = CW'(NODE_LIMIT);
		else n_eff = nc;
	end

	logic skip;
	assign skip = fin_q || (cur_u_q >= n_eff - CW'(1)) || (cur_v_q >= n_eff) ||
		(cur_v_q <= cur_u_q);

	// degrees and intersection count
	always_ff @(posedge clk) begin
		if (cmd.deg_v) du_q <= deg_rd_q;
		if (cmd.deg_cap) begin
			dv_q    <= deg_rd_q;
			inter_q <= '0;
			k_q     <= '0;
		end
		if (cmd.rd_v) wu_q <= adj_rd_q;
		if (cmd.pop) begin
			inter_q <= inter_q + DW'(popcount64(wu_q & adj_rd_q));
			k_q     <= k_q + KW'(1);
		end
	end

	// serial restoring divider: inter * 65536 / union, one quotient bit a cycle
	logic [DW:0] cand;
	assign cand = (div_cnt_q == 5'd0) ? rem_q : {rem_q[DW-1:0], 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			uni_q     <= du_q + dv_q - inter_q;
			rem_q     <= {1'b0, inter_q};
			quot_q    <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (cand >= {1'b0, uni_q}) begin
				rem_q  <= cand - {1'b0, uni_q};
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q  <= cand;
				quot_q <= {quot_q[15:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	// cursor and result
	logic deg_zero;
	assign deg_zero = (du_q == '0) || (dv_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_u_q      <= '0;
			cur_v_q      <= CW'(1);
			fin_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.out_load;
			if (cmd.clr_start) begin
				cur_u_q <= '0;
				cur_v_q <= CW'(1);
				fin_q   <= 1'b0;
			end else if (cmd.out_load && skip) begin
				fin_q <= 1'b1;
			end else if (cmd.out_load) begin
				if (cur_v_q + CW'(1) < n_eff) begin
					cur_v_q <= cur_v_q + CW'(1);
				end else if (cur_u_q + CW'(2) < n_eff) begin
					cur_u_q <= cur_u_q + CW'(1);
					cur_v_q <= cur_u_q + CW'(2);
				end else begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			node_u <= 8'(cur_u_q);
			node_v <= 8'(cur_v_q);
			if (skip || deg_zero) begin
				score_q16 <= '0;
				pair_kept <= 1'b0;
			end else begin
				score_q16 <= quot_q;
				pair_kept <= (quot_q > threshold_q);
			end
			sweep_done <= skip || !((cur_v_q + CW'(1) < n_eff) ||
				(cur_u_q + CW'(2) < n_eff));
		end
	end

	assign st.mode      = mode_q;
	assign st.ep_ok     = (32'(from_q) < NODE_LIMIT) && (32'(to_q) < NODE_LIMIT);
	assign st.same_ends = (from_q == to_q);
	assign st.side      = side_q;
	assign st.skip      = skip;
	assign st.deg_zero  = deg_zero;
	assign st.word_last = (32'(k_q) == RW - 1);
	assign st.div_last  = (32'(div_cnt_q) == QUOT_BITS - 1);
	assign st.clr_last  = (32'(clr_idx_q) == DEPTH - 1);

`ifndef SYNTHESIS
	a_strobe_follows_load: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.out_load))
		else $error("result beat without a load");
	a_kept_above_thr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pair_kept |-> score_q16 > threshold_q)
		else $error("kept pair at or below threshold");
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> score_q16 <= 17'd65536)
		else $error("score above one");
	a_skip_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && skip |=> sweep_done && !pair_kept)
		else $error("skipped pair not marked done");
`endif

endmodule

/* rtl/jaccard_neighbor_similarity.sv */
// Pairwise Jaccard similarity over an adjacency bitmap of up to NODE_LIMIT nodes. Items
// are taken when start is high and busy is low; every evaluate item yields exactly one
// result beat on result_valid one cycle wide, which the receiver must take as it comes.
// After reset and after each clear item the store is swept, one 64-bit row word a cycle,
// over all NODE_LIMIT*ceil(NODE_LIMIT/64) words (1024 at the default) with busy high. An
// add item reads and writes the row word, then does the same for the mirrored bit unless
// both ends are equal; an evaluate item reads both degrees, then both rows word by word
// through the single memory port, then runs the one-bit-a-cycle divider; a skipped pair
// ends after decode, and a pair with an empty neighbor set after the degree check.
module jaccard_neighbor_similarity #(
	parameter int NODE_LIMIT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  edge_from,
	input  logic [7:0]  edge_to,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [16:0] wr_data,
	output logic        result_valid,
	output logic [7:0]  node_u,
	output logic [7:0]  node_v,
	output logic [16:0] score_q16,
	output logic        pair_kept,
	output logic        sweep_done
);
	import jns_pkg::*;

	cmd_t    cmd;
	status_t st;

	jns_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	jns_datapath #(.NODE_LIMIT(NODE_LIMIT)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.mode         (mode),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.result_valid (result_valid),
		.node_u       (node_u),
		.node_v       (node_v),
		.score_q16    (score_q16),
		.pair_kept    (pair_kept),
		.sweep_done   (sweep_done)
	);

endmodule
